### sv/chm_pkg.sv
// Shared constants, codes and sequencer states for the chained hash map engine.
package chm_pkg;

  localparam int ENTRIES     = 32;
  localparam int BUCKETS     = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int BKT_W = $clog2(BUCKETS);
  localparam int ACT_W = 2;
  localparam int OUT_VW = 32;

  localparam int IN_DATA_W  = ((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_RAW_W  = 1 + OUT_VW + 1 + CNT_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ERASE  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HEAD,
    S_WALK,
    S_ACT,
    S_UNLINK,
    S_LREAD,
    S_MOVE,
    S_PUSH,
    S_OUT
  } state_t;

endpackage

### sv/chained_hash_map_engine.sv
// Top level of the chained hash map engine: sequencer, entry stores and bucket heads.
//
// The engine keeps up to ENTRIES key/value pairs in densely packed entry stores, chained
// per bucket (bucket = low bits of the key). Each request is a lookup, insert or erase
// and yields exactly one result carrying found, the looked-up value, a store-full flag
// and the entry count after the request. A single sequencer walks the chains one entry
// per cycle through one shared key comparator, and the engine takes no new request until
// the current one is finished. Each map action walks one chain; an erase that moves the last
// entry into the hole then walks a second chain, that of the moved key. The bucket-head
// memory has a registered read port, so each chain walk starts with a head-read state.
// A finished result waits in an output register; the next request is taken while it
// waits, but it cannot finish until the previous result has been taken. After reset all
// buckets are empty at once.
module chained_hash_map_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata: key [31:0], value [63:32]
  input  logic [chm_pkg::IN_DATA_W-1:0]      in_tdata,
  // in_tuser: action [1:0]
  input  logic [chm_pkg::ACT_W-1:0]          in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata: found [0], value_out [32:1], full_res [33], count [39:34]
  output logic [chm_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import chm_pkg::*;

  // Bucket heads live in a memory; their valid bits are flip-flops cleared by reset.
  logic [IDX_W-1:0]       head_mem [BUCKETS];
  logic [BUCKETS-1:0]     head_v_r;
  logic [IDX_W-1:0]       hd_q_r;
  logic [BKT_W-1:0]       hd_raddr;

  // Entry stores, each read at a single address per cycle.
  logic [KEY_WIDTH-1:0]   key_mem  [ENTRIES];
  logic [VALUE_WIDTH-1:0] val_mem  [ENTRIES];
  logic [IDX_W-1:0]       next_mem [ENTRIES];
  logic [ENTRIES-1:0]     next_v_r;

  state_t state_r, state_nxt;

  logic [ACT_W-1:0]       act_r;
  logic [KEY_WIDTH-1:0]   key_r, lkey_r;
  logic [VALUE_WIDTH-1:0] val_r, lval_r;
  logic [BKT_W-1:0]       bkt_r;
  logic                   pass_r;      // 0: search for the request key, 1: for the moved key
  logic [IDX_W-1:0]       cur_r, prev_r, slot_r, hole_r;
  logic                   cur_v_r, has_prev_r, hit_r;
  logic [CNT_W-1:0]       steps_r, count_r;

  logic                   res_found_r, res_full_r;
  logic [OUT_VW-1:0]      res_val_r;
  logic                   out_v_r;
  logic                   o_found_r, o_full_r;
  logic [OUT_VW-1:0]      o_val_r;
  logic [CNT_W-1:0]       o_cnt_r;

  logic [IDX_W-1:0]       rd_addr;
  logic [KEY_WIDTH-1:0]   rd_key, walk_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [IDX_W-1:0]       rd_next;
  logic                   rd_next_v;
  logic [IDX_W-1:0]       last_idx;
  logic                   in_acc, walk_end, walk_hit, out_load;

  assign in_acc   = in_tvalid && in_tready;
  assign walk_key = pass_r ? lkey_r : key_r;
  assign last_idx = IDX_W'(count_r - CNT_W'(1));
  assign walk_end = !cur_v_r || (steps_r == CNT_W'(ENTRIES));

  // One read address for all entry stores, chosen by the sequencer.
  always_comb begin
    case (state_r)
      S_WALK:   rd_addr = cur_r;
      S_LREAD:  rd_addr = last_idx;
      default:  rd_addr = slot_r;
    endcase
  end

  assign rd_key    = key_mem[rd_addr];
  assign rd_val    = val_mem[rd_addr];
  assign rd_next   = next_mem[rd_addr];
  assign rd_next_v = next_v_r[rd_addr];
  assign walk_hit  = !walk_end && (rd_key == walk_key);

  // Head read address: the request bucket on accept, the moved key's bucket when
  // the second search starts, otherwise the bucket being worked on.
  always_comb begin
    if (state_r == S_IDLE) begin
      hd_raddr = in_tdata[BKT_W-1:0];
    end else if (state_r == S_LREAD) begin
      hd_raddr = rd_key[BKT_W-1:0];
    end else begin
      hd_raddr = bkt_r;
    end
  end

  always_ff @(posedge clk) begin
    hd_q_r <= head_mem[hd_raddr];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc) state_nxt = (in_tuser == ACT_LOOKUP || in_tuser == ACT_INSERT ||
                                         in_tuser == ACT_ERASE) ? S_HEAD : S_OUT;
      S_HEAD:   state_nxt = S_WALK;
      S_WALK:   if (walk_end || walk_hit) state_nxt = S_ACT;
      S_ACT: begin
        if (pass_r) begin
          state_nxt = hit_r ? S_UNLINK : S_MOVE;
        end else if (act_r == ACT_ERASE && hit_r) begin
          state_nxt = S_UNLINK;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_UNLINK: begin
        if (pass_r) begin
          state_nxt = S_MOVE;
        end else begin
          state_nxt = (slot_r != last_idx) ? S_LREAD : S_OUT;
        end
      end
      S_LREAD:  state_nxt = S_HEAD;
      S_MOVE:   state_nxt = S_PUSH;
      S_PUSH:   state_nxt = S_OUT;
      S_OUT:    if (!out_v_r || out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  assign in_tready = (state_r == S_IDLE);
  assign out_load  = (state_r == S_OUT) && (!out_v_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      head_v_r <= '0;
      out_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        S_ACT: begin
          if (!pass_r && act_r == ACT_INSERT && !hit_r && count_r != CNT_W'(ENTRIES)) begin
            head_v_r[bkt_r] <= 1'b1;
            count_r         <= count_r + CNT_W'(1);
          end
        end
        S_UNLINK: begin
          if (!has_prev_r) head_v_r[bkt_r] <= rd_next_v;
          if (!pass_r && slot_r == last_idx) count_r <= CNT_W'(last_idx);
        end
        S_PUSH: begin
          head_v_r[bkt_r] <= 1'b1;
          count_r         <= CNT_W'(last_idx);
        end
        default: ;
      endcase
    end
  end

  // Memory writes and datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          act_r       <= in_tuser;
          key_r       <= in_tdata[KEY_WIDTH-1:0];
          val_r       <= in_tdata[KEY_WIDTH+VALUE_WIDTH-1:KEY_WIDTH];
          bkt_r       <= in_tdata[BKT_W-1:0];
          pass_r      <= 1'b0;
          res_found_r <= 1'b0;
          res_full_r  <= 1'b0;
          res_val_r   <= '0;
        end
      end
      S_HEAD: begin
        cur_r      <= hd_q_r;
        cur_v_r    <= head_v_r[bkt_r];
        has_prev_r <= 1'b0;
        steps_r    <= '0;
        hit_r      <= 1'b0;
      end
      S_WALK: begin
        if (walk_hit) begin
          hit_r  <= 1'b1;
          slot_r <= cur_r;
        end else if (!walk_end) begin
          prev_r     <= cur_r;
          has_prev_r <= 1'b1;
          cur_r      <= rd_next;
          cur_v_r    <= rd_next_v;
          steps_r    <= steps_r + CNT_W'(1);
        end
      end
      S_ACT: begin
        if (!pass_r) begin
          res_found_r <= hit_r;
          hole_r      <= slot_r;
          if (act_r == ACT_LOOKUP && hit_r) begin
            res_val_r <= OUT_VW'(rd_val);
          end
          if (act_r == ACT_INSERT) begin
            if (hit_r) begin
              val_mem[slot_r] <= val_r;
            end else if (count_r == CNT_W'(ENTRIES)) begin
              res_full_r <= 1'b1;
            end else begin
              next_mem[IDX_W'(count_r)] <= hd_q_r;
              next_v_r[IDX_W'(count_r)] <= head_v_r[bkt_r];
              head_mem[bkt_r]           <= IDX_W'(count_r);
              key_mem[IDX_W'(count_r)]  <= key_r;
              val_mem[IDX_W'(count_r)]  <= val_r;
            end
          end
        end
      end
      S_UNLINK: begin
        if (has_prev_r) begin
          next_mem[prev_r] <= rd_next;
          next_v_r[prev_r] <= rd_next_v;
        end else begin
          head_mem[bkt_r] <= rd_next;
        end
      end
      S_LREAD: begin
        lkey_r <= rd_key;
        lval_r <= rd_val;
        bkt_r  <= rd_key[BKT_W-1:0];
        pass_r <= 1'b1;
      end
      S_MOVE: begin
        key_mem[hole_r] <= lkey_r;
        val_mem[hole_r] <= lval_r;
      end
      S_PUSH: begin
        next_mem[hole_r] <= hd_q_r;
        next_v_r[hole_r] <= head_v_r[bkt_r];
        head_mem[bkt_r]  <= hole_r;
      end
      default: ;
    endcase
    if (out_load) begin
      o_found_r <= res_found_r;
      o_val_r   <= res_val_r;
      o_full_r  <= res_full_r;
      o_cnt_r   <= count_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_DATA_W'({o_cnt_r, o_full_r, o_val_r, o_found_r});

  // The entry count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("entry count above capacity");

  // A rejected insert only happens with a full store.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && res_full_r |-> count_r == CNT_W'(ENTRIES))
    else $error("full flag without a full store");

  // Found and full are never reported together.
  a_found_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(res_found_r && res_full_r))
    else $error("found and full both set");

  // A chain walk never runs past the capacity.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> steps_r <= CNT_W'(ENTRIES))
    else $error("chain walk overran");

endmodule

### tb/sv/tb_top.sv
// Self-checking bench for the chained hash map engine: directed table, fill, random traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import chm_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [ACT_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  chained_hash_map_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // One result of the map, as the engine reports it.
  typedef struct packed {
    logic found;
    logic [31:0] value_out;
    logic full_res;
    logic [5:0] count;
  } map_result_t;

  // One request in the directed table. When typed_in is set the expected
  // result is taken from the row itself instead of the predictor.
  typedef struct {
    logic [ACT_W-1:0] action;
    logic [31:0] key;
    logic [31:0] value;
    bit typed_in;
    map_result_t result;
  } map_row_t;

  // Shadow copy of the map. Plain associative lookups stand in for the
  // chains, since the result never shows the chain order.
  logic [31:0] shadow_val[logic [31:0]];
  int shadow_count;

  map_result_t result_queue[$];
  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  int idle_cycles;
  bit stimulus_done;

  // Computes the result of one request and updates the shadow map.
  function automatic map_result_t map_predict(logic [ACT_W-1:0] action, logic [31:0] key,
                                              logic [31:0] value);
    map_result_t r;
    r = '0;
    case (action)
      ACT_LOOKUP: begin
        if (shadow_val.exists(key)) begin
          r.found = 1'b1;
          r.value_out = shadow_val[key];
        end
      end
      ACT_INSERT: begin
        if (shadow_val.exists(key)) begin
          r.found = 1'b1;
          shadow_val[key] = value;
        end else if (shadow_count >= ENTRIES) begin
          r.full_res = 1'b1;
        end else begin
          shadow_val[key] = value;
          shadow_count++;
        end
      end
      ACT_ERASE: begin
        if (shadow_val.exists(key)) begin
          r.found = 1'b1;
          shadow_val.delete(key);
          shadow_count--;
        end
      end
      default: ;
    endcase
    r.count = shadow_count[5:0];
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sends one request, holding it until the engine takes it.
  task automatic send_request(logic [ACT_W-1:0] action, logic [31:0] key,
                              logic [31:0] value);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= action;
    in_tdata <= IN_DATA_W'({value, key});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Predicted or typed-in result goes into the queue at the moment of acceptance.
  task automatic issue(map_row_t row);
    map_result_t predicted;
    predicted = map_predict(row.action, row.key, row.value);
    send_request(row.action, row.key, row.value);
    result_queue.push_back(row.typed_in ? row.result : predicted);
  endtask

  // Receiver: random back pressure and the result check.
  always @(posedge clk) begin
    map_result_t got;
    map_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[0], out_tdata[32:1], out_tdata[33], out_tdata[39:34]};
        if (result_queue.size() == 0) begin
          $display("%0t: result with none expected: actual %h", $time, got);
          errors++;
        end else begin
          want = result_queue.pop_front();
          if (got.found !== want.found || got.value_out !== want.value_out ||
              got.full_res !== want.full_res || got.count !== want.count) begin
            $display({"%0t: mismatch expected found=%0d value=%h full=%0d count=%0d,",
                      " actual found=%0d value=%h full=%0d count=%0d"},
                     $time, want.found, want.value_out, want.full_res, want.count,
                     got.found, got.value_out, got.full_res, got.count);
            errors++;
          end
        end
      end
      out_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: counts cycles with no accepted request on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (rst_n && !(stimulus_done && result_queue.size() == 0)) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Random key from a small pool, so that hits, collisions and a full store are common.
  function automatic logic [31:0] pool_key(int pool);
    logic [31:0] k;
    k = $urandom;
    // Many keys share a bucket: keep the low bits in a narrow range.
    k[5:0] = 6'($urandom_range(3));
    k[31:6] = 26'($urandom_range(pool));
    return k;
  endfunction

  initial begin
    map_row_t table_rows[$];
    map_row_t row;
    int phase;
    int act_pick;
    errors = 0;
    idle_cycles = 0;
    stimulus_done = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    shadow_count = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = ACT_LOOKUP;
    out_tready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: empty-map cases, extremes, overwrite, erase in the
    // middle and at the end, and the unused action.
    table_rows = '{
      '{ACT_LOOKUP, 32'h0,        32'h0,        1'b1, '{1'b0, 32'h0, 1'b0, 6'd0}},
      '{ACT_ERASE,  32'hFFFFFFFF, 32'h0,        1'b1, '{1'b0, 32'h0, 1'b0, 6'd0}},
      '{ACT_INSERT, 32'h0,        32'hFFFFFFFF, 1'b1, '{1'b0, 32'h0, 1'b0, 6'd1}},
      '{ACT_INSERT, 32'hFFFFFFFF, 32'h0,        1'b1, '{1'b0, 32'h0, 1'b0, 6'd2}},
      '{ACT_LOOKUP, 32'h0,        32'h0,        1'b1, '{1'b1, 32'hFFFFFFFF, 1'b0, 6'd2}},
      '{ACT_LOOKUP, 32'hFFFFFFFF, 32'h12345678, 1'b1, '{1'b1, 32'h0, 1'b0, 6'd2}},
      '{ACT_INSERT, 32'h40,       32'hA5A5A5A5, 1'b0, '0},
      '{ACT_INSERT, 32'h80,       32'h5A5A5A5A, 1'b0, '0},
      '{ACT_INSERT, 32'h0,        32'h00000001, 1'b1, '{1'b1, 32'h0, 1'b0, 6'd4}},
      '{ACT_LOOKUP, 32'h40,       32'h0,        1'b0, '0},
      '{ACT_ERASE,  32'h40,       32'h0,        1'b0, '0},
      '{ACT_LOOKUP, 32'h80,       32'h0,        1'b0, '0},
      '{ACT_ERASE,  32'h80,       32'h0,        1'b0, '0},
      '{ACT_ERASE,  32'h80,       32'h0,        1'b1, '{1'b0, 32'h0, 1'b0, 6'd2}},
      '{2'd3,       32'h0,        32'hFFFFFFFF, 1'b1, '{1'b0, 32'h0, 1'b0, 6'd2}},
      '{ACT_LOOKUP, 32'h0,        32'h0,        1'b0, '0},
      '{ACT_ERASE,  32'h0,        32'h0,        1'b0, '0},
      '{ACT_ERASE,  32'hFFFFFFFF, 32'h0,        1'b1, '{1'b1, 32'h0, 1'b0, 6'd0}}
    };
    foreach (table_rows[i]) issue(table_rows[i]);

    // Fill the store to capacity in one bucket pair, then try one more new key and an overwrite.
    for (int i = 0; i < ENTRIES; i++) begin
      row = '{ACT_INSERT, {26'(i), 6'(i % 2)}, $urandom, 1'b0, '0};
      issue(row);
    end
    issue('{ACT_INSERT, 32'hDEADBEEF, 32'h1, 1'b1, '{1'b0, 32'h0, 1'b1, 6'd32}});
    issue('{ACT_INSERT, 32'h0, 32'h77, 1'b0, '0});

    // Random phases with each idling profile, the first without any.
    for (int n = 0; n < 1750; n++) begin
      phase = n / 350;
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      act_pick = $urandom_range(99);
      row.typed_in = 1'b0;
      row.result = '0;
      row.value = $urandom;
      // Mostly map traffic over a small key pool; a few wide keys and unused actions.
      if (act_pick < 2) begin
        row.action = 2'd3;
        row.key = $urandom;
      end else begin
        row.action = (act_pick < 45) ? ACT_INSERT : (act_pick < 75) ? ACT_LOOKUP : ACT_ERASE;
        row.key = (act_pick % 10 == 0) ? 32'($urandom) : pool_key((n / 200) % 2 ? 15 : 60);
      end
      issue(row);
    end
    in_tvalid <= 1'b0;
    stimulus_done = 1'b1;

    while (result_queue.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

### chained_hash_map_engine.f
sv/chm_pkg.sv
sv/chained_hash_map_engine.sv
tb/sv/tb_top.sv
